// ----- src/lhss_pkg.sv -----
// ----------------------------------------------------------------------------
// lhss_pkg
// Shared widths, constants, codes and control types for the laser scan
// sequencer.
// ----------------------------------------------------------------------------
package lhss_pkg;

  // field widths
  localparam int SPACING_W = 12;
  localparam int TIMER_W   = 20;
  localparam int TICKS_W   = 16;
  localparam int DWELL_W   = 20;
  localparam int COUNT_W   = 4;
  localparam int SENSOR_W  = 10;
  localparam int NOTE_W    = 5;
  localparam int DIVCNT_W  = 4;   // counts the SPACING_W divide steps

  // sensors that may set a note bit
  localparam int SENSOR_COUNT = 5;

  // string spacing limits
  localparam logic [SPACING_W-1:0] SPACING_MAX   = 12'd4095;
  localparam logic [SPACING_W-1:0] SPACING_MIN   = 12'd10;
  localparam logic [SPACING_W-1:0] SPACING_RESET = 12'd150;

  // register reset values
  localparam logic [TICKS_W-1:0]  PULSE_RESET  = 16'd50;
  localparam logic [TICKS_W-1:0]  GAP_RESET    = 16'd50;
  localparam logic [DWELL_W-1:0]  DWELL_RESET  = 20'd4000;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = 4'd4;
  localparam logic [SENSOR_W-1:0] THRESH_RESET = 10'd100;

  // APB register map, byte addressed, register index from paddr[4:2]
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  typedef enum logic [2:0] {
    REG_PULSE  = 3'd0,
    REG_GAP    = 3'd1,
    REG_DWELL  = 3'd2,
    REG_COUNT  = 3'd3,
    REG_THRESH = 3'd4
  } reg_idx_t;

  // scan phase
  typedef enum logic [1:0] {
    PH_HIGH  = 2'd0,
    PH_LOW   = 2'd1,
    PH_DWELL = 2'd2
  } phase_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DIVIDE = 2'd1,
    ST_SCAN   = 2'd2,
    ST_DONE   = 2'd3
  } ctrl_state_t;

  // configuration bundle
  typedef struct packed {
    logic [TICKS_W-1:0]  pulse_ticks;
    logic [TICKS_W-1:0]  gap_ticks;
    logic [DWELL_W-1:0]  dwell_ticks;
    logic [COUNT_W-1:0]  string_count;
    logic [SENSOR_W-1:0] note_threshold;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // take the request, update spacing, start divide
    logic div_step;  // one restoring divide step
    logic scan;      // advance the sequencer, load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;  // current divide step is the final one
  } stat_t;

endpackage

// ----- src/lhss_in_if.sv -----
// ----------------------------------------------------------------------------
// lhss_in_if
// Tick request channel: encoder levels and sensor samples.
// ----------------------------------------------------------------------------
interface lhss_in_if;
  logic                           valid;
  logic                           ready;
  logic                           enc_a;
  logic                           enc_b;
  logic [lhss_pkg::SENSOR_W-1:0]  sensor_one;
  logic [lhss_pkg::SENSOR_W-1:0]  sensor_two;
  logic [lhss_pkg::SENSOR_W-1:0]  sensor_three;
  logic [lhss_pkg::SENSOR_W-1:0]  sensor_four;
  logic [lhss_pkg::SENSOR_W-1:0]  sensor_five;

  modport source (
    output valid, enc_a, enc_b, sensor_one, sensor_two, sensor_three,
           sensor_four, sensor_five,
    input  ready
  );
  modport sink (
    input  valid, enc_a, enc_b, sensor_one, sensor_two, sensor_three,
           sensor_four, sensor_five,
    output ready
  );
endinterface

// ----- src/lhss_out_if.sv -----
// ----------------------------------------------------------------------------
// lhss_out_if
// Tick result channel: step, direction, laser, notes and spacing.
// ----------------------------------------------------------------------------
interface lhss_out_if;
  logic                           valid;
  logic                           ready;
  logic                           step_pulse;
  logic                           direction;
  logic                           laser_on;
  logic [lhss_pkg::NOTE_W-1:0]    note_bits;
  logic [lhss_pkg::SPACING_W-1:0] spacing_now;

  modport source (
    output valid, step_pulse, direction, laser_on, note_bits, spacing_now,
    input  ready
  );
  modport sink (
    input  valid, step_pulse, direction, laser_on, note_bits, spacing_now,
    output ready
  );
endinterface

// ----- src/lhss_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lhss_cfg_regs
// APB register file holding the scan timing, string count and threshold.
// ----------------------------------------------------------------------------
module lhss_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lhss_pkg::ADDR_W-1:0]   paddr,
  input  logic [lhss_pkg::DATA_W-1:0]   pwdata,
  output logic [lhss_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output lhss_pkg::cfg_t                cfg
);

  lhss_pkg::reg_idx_t reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = lhss_pkg::reg_idx_t'(paddr[lhss_pkg::ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_ticks    <= lhss_pkg::PULSE_RESET;
      cfg.gap_ticks      <= lhss_pkg::GAP_RESET;
      cfg.dwell_ticks    <= lhss_pkg::DWELL_RESET;
      cfg.string_count   <= lhss_pkg::COUNT_RESET;
      cfg.note_threshold <= lhss_pkg::THRESH_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        lhss_pkg::REG_PULSE:  cfg.pulse_ticks    <= pwdata[lhss_pkg::TICKS_W-1:0];
        lhss_pkg::REG_GAP:    cfg.gap_ticks      <= pwdata[lhss_pkg::TICKS_W-1:0];
        lhss_pkg::REG_DWELL:  cfg.dwell_ticks    <= pwdata[lhss_pkg::DWELL_W-1:0];
        lhss_pkg::REG_COUNT:  cfg.string_count   <= pwdata[lhss_pkg::COUNT_W-1:0];
        lhss_pkg::REG_THRESH: cfg.note_threshold <= pwdata[lhss_pkg::SENSOR_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      lhss_pkg::REG_PULSE:  prdata[lhss_pkg::TICKS_W-1:0]  = cfg.pulse_ticks;
      lhss_pkg::REG_GAP:    prdata[lhss_pkg::TICKS_W-1:0]  = cfg.gap_ticks;
      lhss_pkg::REG_DWELL:  prdata[lhss_pkg::DWELL_W-1:0]  = cfg.dwell_ticks;
      lhss_pkg::REG_COUNT:  prdata[lhss_pkg::COUNT_W-1:0]  = cfg.string_count;
      lhss_pkg::REG_THRESH: prdata[lhss_pkg::SENSOR_W-1:0] = cfg.note_threshold;
      default: prdata = '0;
    endcase
  end

endmodule

// ----- src/lhss_ctrl.sv -----
// ----------------------------------------------------------------------------
// lhss_ctrl
// Controller: takes a request, runs the spacing divide, advances the
// sequencer and holds the result until it is taken.
// ----------------------------------------------------------------------------
module lhss_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  lhss_pkg::stat_t stat,
  output lhss_pkg::cmd_t  cmd
);

  lhss_pkg::ctrl_state_t state;
  lhss_pkg::ctrl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lhss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lhss_pkg::ST_IDLE:   if (in_valid) state_next = lhss_pkg::ST_DIVIDE;
      lhss_pkg::ST_DIVIDE: if (stat.div_last) state_next = lhss_pkg::ST_SCAN;
      lhss_pkg::ST_SCAN:   state_next = lhss_pkg::ST_DONE;
      lhss_pkg::ST_DONE:   if (out_ready) state_next = lhss_pkg::ST_IDLE;
      default:             state_next = lhss_pkg::ST_IDLE;
    endcase
  end

  // outputs; no request is taken while reset is held
  always_comb begin
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.scan     = 1'b0;
    unique case (state)
      lhss_pkg::ST_IDLE: begin
        in_ready = !rst;
        cmd.load = in_valid && !rst;
      end
      lhss_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
      lhss_pkg::ST_SCAN:   cmd.scan = 1'b1;
      lhss_pkg::ST_DONE:   out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- src/lhss_datapath.sv -----
// ----------------------------------------------------------------------------
// lhss_datapath
// Encoder spacing update, serial spacing/string_count divider, scan
// sequencer state and the result register.
// ----------------------------------------------------------------------------
module lhss_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  lhss_pkg::cmd_t                   cmd,
  output lhss_pkg::stat_t                  stat,
  input  lhss_pkg::cfg_t                   cfg,
  input  logic                             enc_a,
  input  logic                             enc_b,
  input  logic [lhss_pkg::SENSOR_W-1:0]    sensor_one,
  input  logic [lhss_pkg::SENSOR_W-1:0]    sensor_two,
  input  logic [lhss_pkg::SENSOR_W-1:0]    sensor_three,
  input  logic [lhss_pkg::SENSOR_W-1:0]    sensor_four,
  input  logic [lhss_pkg::SENSOR_W-1:0]    sensor_five,
  output logic                             step_pulse,
  output logic                             direction,
  output logic                             laser_on,
  output logic [lhss_pkg::NOTE_W-1:0]      note_bits,
  output logic [lhss_pkg::SPACING_W-1:0]   spacing_now
);

  localparam int SW = lhss_pkg::SPACING_W;
  localparam int CW = lhss_pkg::COUNT_W;
  localparam int TW = lhss_pkg::TIMER_W;
  localparam logic [lhss_pkg::DIVCNT_W-1:0] DIV_LAST = lhss_pkg::DIVCNT_W'(SW - 1);

  // spacing and encoder history
  logic [SW-1:0] spacing;
  logic [SW-1:0] spacing_next;
  logic          a_prev;

  // divider
  logic [SW-1:0]                     quot;
  logic [CW-1:0]                     rem;
  logic [lhss_pkg::DIVCNT_W-1:0]     div_cnt;
  logic [CW:0]                       trial;
  logic                              trial_ge;
  logic [CW-1:0]                     count_eff;

  // sampled sensors
  logic [lhss_pkg::SENSOR_W-1:0] sens [lhss_pkg::NOTE_W];
  logic [lhss_pkg::NOTE_W-1:0]   hits;

  // sequencer state
  lhss_pkg::phase_t  phase;
  lhss_pkg::phase_t  phase_next;
  logic [TW-1:0]     timer;
  logic [TW-1:0]     timer_next;
  logic [TW-1:0]     timer_inc;
  logic [SW-1:0]     step_idx;
  logic [SW-1:0]     step_idx_next;
  logic [CW-1:0]     str_idx;
  logic [CW-1:0]     str_idx_next;
  logic [CW-1:0]     str_idx_inc;
  logic              fwd;
  logic              fwd_next;
  logic [lhss_pkg::NOTE_W-1:0] notes;
  logic [lhss_pkg::NOTE_W-1:0] notes_next;
  logic              step_out;
  logic              laser;
  logic [TW-1:0]     limit;

  assign count_eff = (cfg.string_count == '0) ? CW'(1) : cfg.string_count;

  // encoder: rising edge of A moves the spacing, B picks the direction
  always_comb begin
    spacing_next = spacing;
    if (enc_a && !a_prev) begin
      if (!enc_b) begin
        if (spacing < lhss_pkg::SPACING_MAX) spacing_next = spacing + SW'(1);
      end else begin
        if (spacing > lhss_pkg::SPACING_MIN) spacing_next = spacing - SW'(1);
        else                                 spacing_next = lhss_pkg::SPACING_MIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= lhss_pkg::SPACING_RESET;
      a_prev  <= 1'b1;
    end else if (cmd.load) begin
      spacing <= spacing_next;
      a_prev  <= enc_a;
    end
  end

  // sensor capture with the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sens[0] <= sensor_one;
      sens[1] <= sensor_two;
      sens[2] <= sensor_three;
      sens[3] <= sensor_four;
      sens[4] <= sensor_five;
    end
  end

  // restoring divider, one quotient bit per cycle, MSB first
  assign trial    = {rem, quot[SW-1]};
  assign trial_ge = trial >= {1'b0, count_eff};
  assign stat.div_last = (div_cnt == DIV_LAST);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot    <= spacing_next;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= trial_ge ? CW'(trial - {1'b0, count_eff}) : trial[CW-1:0];
      quot    <= {quot[SW-2:0], trial_ge};
      div_cnt <= div_cnt + lhss_pkg::DIVCNT_W'(1);
    end
  end

  // note compare against threshold
  always_comb begin
    for (int i = 0; i < lhss_pkg::NOTE_W; i++) begin
      hits[i] = (i < lhss_pkg::SENSOR_COUNT) && (sens[i] > cfg.note_threshold);
    end
  end

  // one sequencer tick
  always_comb begin
    phase_next    = phase;
    timer_next    = timer;
    step_idx_next = step_idx;
    str_idx_next  = str_idx;
    fwd_next      = fwd;
    notes_next    = notes;
    step_out      = 1'b0;
    laser         = 1'b0;
    limit         = TW'(1);
    timer_inc     = timer + TW'(1);
    str_idx_inc   = str_idx + CW'(1);

    // step count reached (or zero): go to dwell on this tick
    if (phase == lhss_pkg::PH_HIGH && timer == '0 && step_idx >= quot) begin
      phase_next = lhss_pkg::PH_DWELL;
    end

    case (phase_next)
      lhss_pkg::PH_LOW: begin
        limit = (cfg.gap_ticks == '0) ? TW'(1) : TW'(cfg.gap_ticks);
        timer_next = timer_inc;
        if (timer_inc >= limit) begin
          timer_next    = '0;
          step_idx_next = step_idx + SW'(1);
          phase_next    = lhss_pkg::PH_HIGH;
        end
      end
      lhss_pkg::PH_DWELL: begin
        laser = 1'b1;
        if (timer == '0 && fwd) notes_next = hits;
        limit = (cfg.dwell_ticks == '0) ? TW'(1) : cfg.dwell_ticks;
        timer_next = timer_inc;
        if (timer_inc >= limit) begin
          timer_next    = '0;
          step_idx_next = '0;
          phase_next    = lhss_pkg::PH_HIGH;
          str_idx_next  = str_idx_inc;
          if (str_idx_inc >= count_eff) begin
            str_idx_next = '0;
            fwd_next     = !fwd;
          end
        end
      end
      default: begin
        // step high
        step_out = 1'b1;
        limit = (cfg.pulse_ticks == '0) ? TW'(1) : TW'(cfg.pulse_ticks);
        timer_next = timer_inc;
        if (timer_inc >= limit) begin
          timer_next = '0;
          phase_next = lhss_pkg::PH_LOW;
        end
      end
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= lhss_pkg::PH_HIGH;
      timer    <= '0;
      step_idx <= '0;
      str_idx  <= '0;
      fwd      <= 1'b1;
      notes    <= '0;
    end else if (cmd.scan) begin
      phase    <= phase_next;
      timer    <= timer_next;
      step_idx <= step_idx_next;
      str_idx  <= str_idx_next;
      fwd      <= fwd_next;
      notes    <= notes_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      step_pulse  <= step_out;
      direction   <= fwd_next;
      laser_on    <= laser;
      note_bits   <= notes_next;
      spacing_now <= spacing;
    end
  end

endmodule

// ----- src/laser_harp_scan_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// laser_harp_scan_sequencer_core
// Tick-driven scan controller for a stepper-swept laser: encoder spacing
// adjust, step pulse / dwell sequencing and note latching.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-------------------------------------
//  sample   | in  | valid/ready        | enc_a, enc_b, sensor_one..five
//  result   | out | valid/ready        | step_pulse, direction, laser_on,
//           |     |                    | note_bits, spacing_now
//  apb      | in  | psel/penable       | paddr, pwdata, prdata, pready
//
//  One tick request passes in order through accept, the bit-serial
//  spacing/string_count divider, the sequencer update and the result
//  register; the result is then valid and holds while result.ready is
//  low. A new request is taken the cycle after the previous result is
//  taken. Synchronous active-high reset; no clearing pass, ready as soon
//  as reset is released.
// ----------------------------------------------------------------------------
module laser_harp_scan_sequencer_core (
  input  logic                          clk,
  input  logic                          rst,
  lhss_in_if.sink                       sample,
  lhss_out_if.source                    result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lhss_pkg::ADDR_W-1:0]   paddr,
  input  logic [lhss_pkg::DATA_W-1:0]   pwdata,
  output logic [lhss_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  lhss_pkg::cfg_t  cfg;
  lhss_pkg::cmd_t  cmd;
  lhss_pkg::stat_t stat;

  lhss_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lhss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lhss_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg          (cfg),
    .enc_a        (sample.enc_a),
    .enc_b        (sample.enc_b),
    .sensor_one   (sample.sensor_one),
    .sensor_two   (sample.sensor_two),
    .sensor_three (sample.sensor_three),
    .sensor_four  (sample.sensor_four),
    .sensor_five  (sample.sensor_five),
    .step_pulse   (result.step_pulse),
    .direction    (result.direction),
    .laser_on     (result.laser_on),
    .note_bits    (result.note_bits),
    .spacing_now  (result.spacing_now)
  );

endmodule

// ----- src/lhss_checker.sv -----
// ----------------------------------------------------------------------------
// lhss_checker
// Port-level checks for the scan sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module lhss_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           step_pulse,
  input logic                           direction,
  input logic                           laser_on,
  input logic [lhss_pkg::NOTE_W-1:0]    note_bits,
  input logic [lhss_pkg::SPACING_W-1:0] spacing_now
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(step_pulse) &&
      $stable(direction) && $stable(laser_on) && $stable(note_bits) &&
      $stable(spacing_now))
    else $error("stalled result changed");

  // a request never yields its result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early after request");

  // step line and laser are never on in the same tick
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(step_pulse && laser_on))
    else $error("step and laser both active");

  // spacing stays within its clamp
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> spacing_now >= lhss_pkg::SPACING_MIN)
    else $error("spacing below minimum");

endmodule

bind laser_harp_scan_sequencer_core lhss_checker u_lhss_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample.valid),
  .in_ready    (sample.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .step_pulse  (result.step_pulse),
  .direction   (result.direction),
  .laser_on    (result.laser_on),
  .note_bits   (result.note_bits),
  .spacing_now (result.spacing_now)
);
